### sv/sactm_pkg.sv
package sactm_pkg;

	// Default geometry
	localparam int WAYS_DEF       = 2;
	localparam int SETS_DEF       = 128;
	localparam int LINE_BYTES_DEF = 16;

	// Fixed field widths
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 32;

	// Victim LFSR: x^16 + x^14 + x^13 + x^11 + 1, shifting right
	localparam int          LFSR_W    = 16;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;

	// Request types
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Lookup sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_VICTIM,
		ST_WRITE
	} seq_state_t;

endpackage

### sv/sactm_victim.sv
module sactm_victim import sactm_pkg::*; #(
	parameter int WAYS = WAYS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  done,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] way
);

	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	// Reciprocal of WAYS: exact floor division for any LFSR_W-bit value
	localparam int RCP_L  = (WAYS > 1) ? $clog2(WAYS) : 0;
	localparam int RCP_S  = LFSR_W + RCP_L;
	localparam int RCP_W  = LFSR_W + 1;
	localparam int PROD_W = RCP_S + LFSR_W;
	localparam logic [RCP_W-1:0] RCP_M = RCP_W'(((1 << RCP_S) + WAYS - 1) / WAYS);

	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_nxt;
	logic [PROD_W-1:0] prod;
	logic [LFSR_W-1:0] quot;
	logic [LFSR_W-1:0] rem_full;
	logic              busy_q;

	// Advance the LFSR one step
	assign lfsr_nxt = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};

	// Reduce the new LFSR value modulo WAYS by reciprocal multiply
	assign prod     = PROD_W'(lfsr_q) * PROD_W'(RCP_M);
	assign quot     = prod[RCP_S +: LFSR_W];
	assign rem_full = lfsr_q - LFSR_W'(quot * LFSR_W'(WAYS));

	assign done = busy_q;
	assign way  = rem_full[WAY_W-1:0];

	// Step the LFSR on start, flag the pick in the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
			if (start)
				lfsr_q <= lfsr_nxt;
		end
	end

endmodule

### sv/set_assoc_cache_tag_model_top.sv
// Tag-only set-associative write-back cache model with random replacement. After reset the
// block sweeps the tag memory, one set per cycle, and stalls input meanwhile. Each access
// then reads the set's row, compares the ways one at a time (1 to WAYS ways; the search stops
// at the first hit), reduces the LFSR victim modulo WAYS when the set is full, and writes the
// updated row back, waiting while an earlier result is still held by out_stall. The single
// tag comparator steps one way per cycle over a row read from the one-port tag memory.
// hit_count and miss_count hold the running totals that include the shown result.
module set_assoc_cache_tag_model_top import sactm_pkg::*; #(
	parameter int WAYS       = WAYS_DEF,
	parameter int SETS       = SETS_DEF,
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [ADDR_W-1:0] addr,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              writeback,
	output logic              way_used,
	output logic [CNT_W-1:0]  hit_count,
	output logic [CNT_W-1:0]  miss_count
);

	localparam int OFF_W = $clog2(LINE_BYTES);
	localparam int SET_W = $clog2(SETS);
	localparam int SHIFT = OFF_W + SET_W;
	localparam int TAG_W = ADDR_W - SHIFT;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W = TAG_W + 2;
	localparam int V_BIT = ENT_W - 1;
	localparam int D_BIT = ENT_W - 2;

	typedef logic [WAYS-1:0][ENT_W-1:0] row_t;

	seq_state_t state_q, state_d;

	row_t             tag_mem [SETS];
	row_t             rd_row_s1;
	row_t             new_row;
	row_t             mem_wdata;
	logic [SET_W-1:0] mem_addr;
	logic             mem_we;

	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_q;
	logic [SET_W-1:0] set_raw;
	logic [SET_W-1:0] set_red;
	logic [TAG_W-1:0] tag_q;
	logic             wr_q;
	logic [WAY_W-1:0] way_q;
	logic [WAY_W-1:0] inv_way_q;
	logic [WAY_W-1:0] vic_way_q;
	logic [WAY_W-1:0] sel_way;
	logic             hit_q;
	logic             inv_found_q;

	logic [ENT_W-1:0] cur_ent;
	logic             match;
	logic             last_way;
	logic             accept;
	logic             commit;
	logic             vic_start;
	logic             vic_done;
	logic [WAY_W-1:0] vic_way;
	logic             wb;
	logic             hit_inc;
	logic [1:0]       miss_inc;

	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic             out_valid_q;
	logic             out_hit_q;
	logic             out_wb_q;
	logic             out_way_q;

	// Split the address; fold an index of SETS or more back into range
	assign set_raw = addr[SHIFT-1:OFF_W];
	assign set_red = ({1'b0, set_raw} >= (SET_W + 1)'(SETS))
		? SET_W'({1'b0, set_raw} - (SET_W + 1)'(SETS)) : set_raw;

	// Shared tag comparator, one way per cycle
	assign cur_ent  = rd_row_s1[way_q];
	assign match    = cur_ent[V_BIT] && (cur_ent[TAG_W-1:0] == tag_q);
	assign last_way = (way_q == WAY_W'(WAYS - 1));

	assign accept = (state_q == ST_IDLE) && in_valid;
	assign commit = (state_q == ST_WRITE) && (!out_valid_q || !out_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_READ;
			ST_READ:   state_d = ST_CMP;
			ST_CMP: begin
				if (match)
					state_d = ST_WRITE;
				else if (last_way)
					state_d = (inv_found_q || !cur_ent[V_BIT]) ? ST_WRITE : ST_VICTIM;
			end
			ST_VICTIM: if (vic_done) state_d = ST_WRITE;
			ST_WRITE:  if (commit) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		vic_start = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_CMP:  vic_start = !match && last_way && !inv_found_q && cur_ent[V_BIT];
			default: begin
				in_stall  = 1'b1;
				vic_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= SET_W'(clr_q + 1'b1);
		end
	end

	// Victim picker
	sactm_victim #(
		.WAYS(WAYS)
	) u_victim (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vic_start),
		.done   (vic_done),
		.way    (vic_way)
	);

	// Capture the request and track the way search
	always_ff @(posedge clk) begin
		if (accept) begin
			set_q       <= set_red;
			tag_q       <= addr[ADDR_W-1:SHIFT];
			wr_q        <= req_type;
			way_q       <= '0;
			hit_q       <= 1'b0;
			inv_found_q <= 1'b0;
		end else if (state_q == ST_CMP) begin
			if (match) begin
				hit_q <= 1'b1;
			end else begin
				if (!cur_ent[V_BIT] && !inv_found_q) begin
					inv_found_q <= 1'b1;
					inv_way_q   <= way_q;
				end
				if (!last_way)
					way_q <= WAY_W'(way_q + 1'b1);
			end
		end
		if ((state_q == ST_VICTIM) && vic_done)
			vic_way_q <= vic_way;
	end

	// Update the selected way
	assign sel_way = hit_q ? way_q : (inv_found_q ? inv_way_q : vic_way_q);
	assign wb      = !hit_q && !inv_found_q && rd_row_s1[sel_way][D_BIT];

	always_comb begin
		new_row = rd_row_s1;
		if (hit_q) begin
			if (wr_q == REQ_WRITE)
				new_row[sel_way][D_BIT] = 1'b1;
		end else begin
			new_row[sel_way] = {1'b1, wr_q, tag_q};
		end
	end

	// Tag memory: sweep to zero after reset, else write the updated row
	assign mem_we    = (state_q == ST_CLEAR) || commit;
	assign mem_addr  = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we)
			tag_mem[mem_addr] <= mem_wdata;
		if (state_q == ST_READ)
			rd_row_s1 <= tag_mem[set_q];
	end

	// Counters: every write and every read hit count a hit
	assign hit_inc  = (wr_q == REQ_WRITE) || hit_q;
	assign miss_inc = 2'(!hit_q && (wr_q == REQ_READ)) + 2'(wb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				hits_q      <= hits_q + CNT_W'(hit_inc);
				misses_q    <= misses_q + CNT_W'(miss_inc);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload until transfer
	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q <= hit_q;
			out_wb_q  <= wb;
			out_way_q <= sel_way[0];
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign writeback  = out_wb_q;
	assign way_used   = out_way_q;
	assign hit_count  = hits_q;
	assign miss_count = misses_q;

endmodule

### sv/sactm_check.sv
module sactm_check import sactm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              req_type,
	input logic [ADDR_W-1:0] addr,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic              writeback,
	input logic              way_used,
	input logic [CNT_W-1:0]  hit_count,
	input logic [CNT_W-1:0]  miss_count
);

	logic [CNT_W-1:0] prev_hits_q;
	logic [CNT_W-1:0] prev_misses_q;
	logic [CNT_W-1:0] d_hits;
	logic [CNT_W-1:0] d_misses;

	// Track the totals of the last transferred result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_hits_q   <= '0;
			prev_misses_q <= '0;
		end else if (out_valid && !out_stall) begin
			prev_hits_q   <= hit_count;
			prev_misses_q <= miss_count;
		end
	end

	assign d_hits   = hit_count - prev_hits_q;
	assign d_misses = miss_count - prev_misses_q;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(writeback)
			&& $stable(way_used) && $stable(hit_count) && $stable(miss_count))
		else $error("stalled result changed");

	// One access at a time: input stalls right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an access is in progress");

	// A writeback only comes with a miss
	a_wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && writeback))
		else $error("writeback on a hit");

	// Each result adds at most one hit, and a hit always adds one
	a_hit_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (d_hits == CNT_W'(1)) || (d_hits == '0 && !hit))
		else $error("hit counter step wrong");

	// Each result adds at most two misses; none on a hit, one at least on a writeback
	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit && d_misses == '0)
			|| (!hit && !writeback && (d_misses == '0 || d_misses == CNT_W'(1)))
			|| (!hit && writeback && (d_misses == CNT_W'(1) || d_misses == CNT_W'(2))))
		else $error("miss counter step wrong");

endmodule

bind set_assoc_cache_tag_model_top sactm_check u_sactm_check (.*);
